@@ rtl/nsmf_pkg.sv @@
// nsmf_pkg: shared types and constants of the nth substring match finder
// no dependencies; imported by nsmf_cell and nth_substring_match_finder_unit
`timescale 1ns / 1ps

package nsmf_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int TEXT_MAX    = 65536;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int IDX_W       = 3;
  localparam int POS_W       = 17;
  localparam int CNT_W       = 16;
  localparam int PAT_W       = PATTERN_MAX * BYTE_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  cell_idx_t;
  typedef logic [PAT_W-1:0]  pattern_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES     = 2'd0,
    CFG_PATTERN_LENGTH    = 2'd1,
    CFG_OCCURRENCE_WANTED = 2'd2
  } cfg_reg_t;

  // control from the top level to every cell of the history chain
  typedef struct packed {
    logic shift;  // take the neighbor byte
    logic clear;  // end of text, wipe the stored byte
  } cell_ctrl_t;

endpackage

@@ rtl/nth_substring_match_finder_unit.sv @@
// nth_substring_match_finder_unit: top level of the nth substring match finder
// depends on nsmf_pkg and nsmf_cell
`timescale 1ns / 1ps

// Searches a byte stream for a pattern of 1 to 8 bytes held in configuration
// registers and reports, on the final byte of each text (in_tlast), the start
// position of the wanted occurrence. Matches overlap and are counted in order
// of start position; occurrence_wanted picks one counted from one, and zero or
// a number beyond the matches found reports the last match. Counting stops
// once the wanted match is reached. Barring stalls, one request goes in per
// clock: the text runs through a chain of eight byte cells, each comparing its
// byte with the pattern byte that lines up with it, so a whole window is
// checked in the cycle its newest byte arrives. One result per text appears
// in the cycle after its final byte, held in an output register; the input
// stalls only while that register is full and not being taken. Bytes beyond
// 65536 are not compared and set the overflow flag. Configuration writes are
// always taken (cfg_ready is tied high) and must only happen while no text is
// in flight.
module nth_substring_match_finder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input text, one character per request
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] text_char
  input  logic                          in_tlast,   // last_char
  // result, one per text
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] match_index
  output logic [1:0]                    out_tuser,  // [0] found, [1] overflow
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nsmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsmf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nsmf_pkg::*;

  // configuration registers
  pattern_t           pattern_r, pattern_nxt;
  len_t               plen_r, plen_nxt;
  logic [CNT_W-1:0]   wanted_r, wanted_nxt;

  // per-text state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   best_r, best_nxt;
  logic               any_r, any_nxt;
  logic               done_r, done_nxt;

  // output register
  logic               ovld_r, ovld_nxt;
  logic [CNT_W-1:0]   oidx_r, oidx_nxt;
  logic               ofound_r, ofound_nxt;
  logic               oovf_r, oovf_nxt;

  logic               in_fire;
  logic               in_window;   // position still below the text limit
  logic               hit;
  len_t               len_eff;
  logic [CNT_W-1:0]   cnt_inc;
  cell_ctrl_t         ctrl;
  byte_t              chain [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_eq;

  assign cfg_ready = 1'b1;
  assign in_tready = !ovld_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // pattern length 0 acts as 1, anything above the maximum as the maximum
  always_comb begin
    if (plen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_r > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = plen_r;
    end
  end

  assign in_window  = pos_r < POS_W'(TEXT_MAX);
  assign ctrl.shift = in_fire && in_window;
  assign ctrl.clear = in_fire && in_tlast;

  // history chain: stage 0 sees the incoming byte, stage d the byte d back
  assign chain[0] = in_tdata;

  for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
    if (gi < PATTERN_MAX - 1) begin : g_mid
      nsmf_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .idx     (IDX_W'(gi)),
        .len     (len_eff),
        .pattern (pattern_r),
        .din     (chain[gi]),
        .dout    (chain[gi+1]),
        .eq      (cell_eq[gi])
      );
    end else begin : g_end
      // the oldest byte is never needed again
      nsmf_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .idx     (IDX_W'(gi)),
        .len     (len_eff),
        .pattern (pattern_r),
        .din     (chain[gi]),
        .dout    (),
        .eq      (cell_eq[gi])
      );
    end
  end

  // a match needs the whole window inside the text
  assign hit = ctrl.shift && !done_r && &cell_eq
               && ((pos_r + POS_W'(1)) >= POS_W'(len_eff));

  assign cnt_inc = (cnt_r != '1) ? cnt_r + CNT_W'(1) : cnt_r;

  // configuration write decode
  always_comb begin
    pattern_nxt = pattern_r;
    plen_nxt    = plen_r;
    wanted_nxt  = wanted_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:     pattern_nxt = cfg_data[PAT_W-1:0];
        CFG_PATTERN_LENGTH:    plen_nxt    = cfg_data[LEN_W-1:0];
        CFG_OCCURRENCE_WANTED: wanted_nxt  = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-text search state and result capture
  always_comb begin
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    best_nxt   = best_r;
    any_nxt    = any_r;
    done_nxt   = done_r;
    ovld_nxt   = ovld_r && !out_tready;
    oidx_nxt   = oidx_r;
    ofound_nxt = ofound_r;
    oovf_nxt   = oovf_r;
    if (in_fire) begin
      if (hit) begin
        best_nxt = CNT_W'(pos_r + POS_W'(1) - POS_W'(len_eff));
        any_nxt  = 1'b1;
        cnt_nxt  = cnt_inc;
        if (wanted_r != '0 && cnt_inc == wanted_r) begin
          done_nxt = 1'b1;
        end
      end
      // saturates one past the limit to mark overflow
      if (pos_r <= POS_W'(TEXT_MAX)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (in_tlast) begin
        ovld_nxt   = 1'b1;
        ofound_nxt = any_nxt;
        oidx_nxt   = any_nxt ? best_nxt : '0;
        oovf_nxt   = pos_nxt > POS_W'(TEXT_MAX);
        pos_nxt    = '0;
        cnt_nxt    = '0;
        best_nxt   = '0;
        any_nxt    = 1'b0;
        done_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= LEN_W'(1);
      wanted_r  <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      best_r    <= '0;
      any_r     <= 1'b0;
      done_r    <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      pattern_r <= pattern_nxt;
      plen_r    <= plen_nxt;
      wanted_r  <= wanted_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      best_r    <= best_nxt;
      any_r     <= any_nxt;
      done_r    <= done_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    oidx_r   <= oidx_nxt;
    ofound_r <= ofound_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = oidx_r;
  assign out_tuser  = {oovf_r, ofound_r};

endmodule

@@ rtl/nsmf_cell.sv @@
// nsmf_cell: one stage of the history chain, compares the byte it sees
// against its pattern byte and passes that byte on to the next stage
// depends on nsmf_pkg
`timescale 1ns / 1ps

module nsmf_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nsmf_pkg::cell_ctrl_t  ctrl,
  input  nsmf_pkg::cell_idx_t   idx,      // distance from the newest byte
  input  nsmf_pkg::len_t        len,      // effective pattern length, 1..8
  input  nsmf_pkg::pattern_t    pattern,
  input  nsmf_pkg::byte_t       din,
  output nsmf_pkg::byte_t       dout,
  output logic                  eq
);
  import nsmf_pkg::*;

  byte_t hold_r;
  byte_t hold_nxt;
  len_t  sel;
  byte_t pat_byte;
  logic  active;

  // byte at distance idx lines up with pattern byte len-1-idx
  always_comb begin
    active   = {1'b0, idx} < len;
    sel      = len - LEN_W'(1) - {1'b0, idx};
    pat_byte = pattern[sel[IDX_W-1:0]*BYTE_W +: BYTE_W];
    eq       = !active || (din == pat_byte);
  end

  always_comb begin
    hold_nxt = hold_r;
    if (ctrl.clear) begin
      hold_nxt = '0;
    end else if (ctrl.shift) begin
      hold_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  assign dout = hold_r;

endmodule
